// ===== sv/wrt_pkg.sv =====
// ----------------------------------------------------------------------------
// wrt_pkg: shared codes for the watchpoint range table
// Operation codes of the request channel and status codes of the result.
// ----------------------------------------------------------------------------
package wrt_pkg;

  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;
  localparam logic [1:0] MODE_SYNC = 2'd3;

  localparam logic [3:0] ST_SET     = 4'd0;
  localparam logic [3:0] ST_ALREADY = 4'd1;
  localparam logic [3:0] ST_FULL    = 4'd2;
  localparam logic [3:0] ST_DELETED = 4'd3;
  localparam logic [3:0] ST_NOTSET  = 4'd4;
  localparam logic [3:0] ST_HIT     = 4'd5;
  localparam logic [3:0] ST_NEAR    = 4'd6;
  localparam logic [3:0] ST_MISS    = 4'd7;
  localparam logic [3:0] ST_SYNCED  = 4'd8;

  typedef logic [3:0] status_t;

endpackage

// ===== sv/watchpoint_range_table.sv =====
// ----------------------------------------------------------------------------
// watchpoint_range_table: address-range watchpoint table
// A sync skips the scan; find and set/delete scan the table with one compare per
// entry per cycle, and a set/delete that changes the table adds a rank update
// sweep over the rank RAM. One transaction at a time; the next request is taken
// in the cycle after the result register loads.
// Reset clears valid bits, the pending flag and the control state; RAM contents
// are left as they are and no clearing pass runs.
// ----------------------------------------------------------------------------
module watchpoint_range_table
  import wrt_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 32,
  parameter int PAGE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_space_id,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic        out_step_request,
  output logic        out_protect_pending
);

  localparam int IDX_W = $clog2(ENTRIES > 1 ? ENTRIES : 2);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int RW    = IDX_W;
  localparam int AB    = ADDR_BITS;
  localparam int DW    = 16 + 2 * AB;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [15:0]        space_r, space_nxt;
  logic [AB-1:0]      a_r, a_nxt;
  logic [AB-1:0]      hi_new_r, hi_new_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pv_r, pv_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               pending_r, pending_nxt;
  logic               dup_r, dup_nxt;
  logic               slot_found_r, slot_found_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               hit_r, hit_nxt;
  logic               near_r, near_nxt;
  logic               best_found_r, best_found_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [RW-1:0]      best_rank_r, best_rank_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_step_r, out_step_nxt;
  logic               out_pend_r, out_pend_nxt;

  logic               accept;
  logic               scan_go;
  logic [IDX_W-1:0]   rd_addr;
  logic [AB-1:0]      in_a, in_sz, in_hi;

  logic               d_we;
  logic [DW-1:0]      d_wdata, d_rdata;
  logic               k_we;
  logic [IDX_W-1:0]   k_waddr;
  logic [RW-1:0]      k_wdata, k_rdata;

  logic [15:0]        e_space;
  logic [AB-1:0]      e_low, e_high, lo_pg, hi_pg;
  logic [AB-PAGE_BITS-1:0] hi_pg_top;
  logic               e_valid, e_match, e_contain, e_near, e_dup;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign scan_go  = (cnt_r != CNT_W'(ENTRIES));
  assign rd_addr  = cnt_r[IDX_W-1:0];

  assign in_a  = AB'(in_addr);
  assign in_sz = AB'(in_size);
  assign in_hi = in_a + in_sz;

  // entry compare, one entry per cycle on the registered RAM output
  assign e_space   = d_rdata[DW-1 -: 16];
  assign e_low     = d_rdata[2*AB-1 -: AB];
  assign e_high    = d_rdata[AB-1:0];
  assign e_valid   = valid_r[pidx_r];
  assign e_match   = e_valid && (e_space == space_r);
  assign e_contain = (e_low <= a_r) && (a_r < e_high);
  assign e_dup     = (e_low == a_r) && (e_high == hi_new_r);
  assign lo_pg     = {e_low[AB-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
  // round the end up to a page; wraps to zero at the top of the space
  assign hi_pg_top = e_high[AB-1:PAGE_BITS] + (AB-PAGE_BITS)'(|e_high[PAGE_BITS-1:0]);
  assign hi_pg     = {hi_pg_top, {PAGE_BITS{1'b0}}};
  assign e_near    = (lo_pg <= a_r) && (a_r < hi_pg);

  assign d_wdata = {space_r, a_r, hi_new_r};

  wrt_ram #(
    .WIDTH(DW),
    .DEPTH(ENTRIES)
  ) u_data_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(slot_r),
    .wdata(d_wdata),
    .raddr(rd_addr),
    .rdata(d_rdata)
  );

  wrt_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_rank_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(k_waddr),
    .wdata(k_wdata),
    .raddr(rd_addr),
    .rdata(k_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    space_nxt      = space_r;
    a_nxt          = a_r;
    hi_new_nxt     = hi_new_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = pv_r;
    pidx_nxt       = pidx_r;
    valid_nxt      = valid_r;
    pending_nxt    = pending_r;
    dup_nxt        = dup_r;
    slot_found_nxt = slot_found_r;
    slot_nxt       = slot_r;
    hit_nxt        = hit_r;
    near_nxt       = near_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    best_rank_nxt  = best_rank_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_step_nxt   = out_step_r;
    out_pend_nxt   = out_pend_r;
    d_we           = 1'b0;
    k_we           = 1'b0;
    k_waddr        = pidx_r;
    k_wdata        = k_rdata;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt       = in_mode;
          space_nxt      = in_space_id;
          a_nxt          = in_a;
          hi_new_nxt     = in_hi;
          cnt_nxt        = '0;
          pv_nxt         = 1'b0;
          dup_nxt        = 1'b0;
          slot_found_nxt = 1'b0;
          hit_nxt        = 1'b0;
          near_nxt       = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = (in_mode == MODE_SYNC) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_go) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        pv_nxt   = scan_go;
        pidx_nxt = rd_addr;
        if (pv_r) begin
          if (!e_valid && !slot_found_r) begin
            slot_found_nxt = 1'b1;
            slot_nxt       = pidx_r;
          end
          if (e_match) begin
            if (e_dup) begin
              dup_nxt = 1'b1;
            end
            if (e_contain) begin
              hit_nxt = 1'b1;
              if (!best_found_r || (k_rdata < best_rank_r)) begin
                best_found_nxt = 1'b1;
                best_nxt       = pidx_r;
                best_rank_nxt  = k_rdata;
              end
            end
            if (e_near) begin
              near_nxt = 1'b1;
            end
          end
        end
        if (!scan_go && !pv_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_nxt   = '0;
        pv_nxt    = 1'b0;
        state_nxt = S_FIN;
        unique case (mode_r)
          MODE_SET: begin
            if (dup_r) begin
              status_nxt = ST_ALREADY;
            end else if (!slot_found_r) begin
              status_nxt = ST_FULL;
            end else begin
              // new entry written now; it turns valid after the age sweep
              d_we       = 1'b1;
              k_we       = 1'b1;
              k_waddr    = slot_r;
              k_wdata    = '0;
              status_nxt = ST_SET;
              state_nxt  = S_UPD;
            end
          end
          MODE_DEL: begin
            if (!best_found_r) begin
              status_nxt = ST_NOTSET;
            end else begin
              valid_nxt[best_r] = 1'b0;
              status_nxt        = ST_DELETED;
              state_nxt         = S_UPD;
            end
          end
          MODE_FIND: begin
            if (hit_r) begin
              status_nxt = ST_HIT;
            end else if (near_r) begin
              status_nxt  = ST_NEAR;
              pending_nxt = 1'b1;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          MODE_SYNC: begin
            pending_nxt = 1'b0;
            status_nxt  = ST_SYNCED;
          end
          default: begin
            status_nxt = ST_SYNCED;
          end
        endcase
      end
      S_UPD: begin
        // age sweep: read rank of entry i, write it back in the next cycle
        if (scan_go) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        pv_nxt   = scan_go;
        pidx_nxt = rd_addr;
        if (pv_r && e_valid) begin
          if (mode_r == MODE_SET) begin
            k_we    = 1'b1;
            k_wdata = k_rdata + 1'b1;
          end else if (k_rdata > best_rank_r) begin
            k_we    = 1'b1;
            k_wdata = k_rdata - 1'b1;
          end
        end
        if (!scan_go && !pv_r) begin
          if (mode_r == MODE_SET) begin
            valid_nxt[slot_r] = 1'b1;
            pending_nxt       = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_step_nxt   = (status_r == ST_NEAR);
          out_pend_nxt   = pending_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    space_r      <= space_nxt;
    a_r          <= a_nxt;
    hi_new_r     <= hi_new_nxt;
    pidx_r       <= pidx_nxt;
    dup_r        <= dup_nxt;
    slot_found_r <= slot_found_nxt;
    slot_r       <= slot_nxt;
    hit_r        <= hit_nxt;
    near_r       <= near_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    best_rank_r  <= best_rank_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_step_r   <= out_step_nxt;
    out_pend_r   <= out_pend_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_step_request    = out_step_r;
  assign out_protect_pending = out_pend_r;

endmodule

// ===== sv/wrt_ram.sv =====
// ----------------------------------------------------------------------------
// wrt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/wrt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// wrt_tb_pkg: scoreboard for the watchpoint range table testbench
// Keeps a shadow copy of the watchpoint table, predicts the reply of every
// accepted request and checks the replies in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package wrt_tb_pkg;
  import wrt_pkg::*;

  localparam int          TABLE_DEPTH = 64;
  localparam logic [31:0] PAGE_MASK   = 32'h0000_0FFF;

  typedef struct packed {
    status_t status;
    logic    step;
    logic    pend;
  } table_reply_t;

  class wrt_scoreboard;
    bit              slot_used [TABLE_DEPTH];
    logic [15:0]     slot_space[TABLE_DEPTH];
    logic [31:0]     slot_lo   [TABLE_DEPTH];
    logic [31:0]     slot_hi   [TABLE_DEPTH];
    // larger stamp = more recently set
    longint unsigned slot_stamp[TABLE_DEPTH];
    longint unsigned set_count;
    bit              resync_needed;
    table_reply_t    replies_due[$];
    int              errors;

    function new();
      set_count     = 0;
      resync_needed = 0;
      errors        = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function status_t apply_set(logic [15:0] sp, logic [31:0] a, logic [31:0] sz);
      logic [31:0] hi;
      int          free;
      hi   = a + sz;
      free = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_used[i]) begin
          if (slot_space[i] == sp && slot_lo[i] == a && slot_hi[i] == hi) return ST_ALREADY;
        end else if (free < 0) begin
          free = i;
        end
      end
      if (free < 0) return ST_FULL;
      set_count++;
      slot_used[free]  = 1;
      slot_space[free] = sp;
      slot_lo[free]    = a;
      slot_hi[free]    = hi;
      slot_stamp[free] = set_count;
      resync_needed    = 1;
      return ST_SET;
    endfunction

    function status_t apply_delete(logic [15:0] sp, logic [31:0] a);
      int newest;
      newest = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_used[i] && slot_space[i] == sp && slot_lo[i] <= a && a < slot_hi[i]) begin
          if (newest < 0 || slot_stamp[i] > slot_stamp[newest]) newest = i;
        end
      end
      if (newest < 0) return ST_NOTSET;
      slot_used[newest] = 0;
      return ST_DELETED;
    endfunction

    function status_t apply_find(logic [15:0] sp, logic [31:0] a);
      bit          near;
      logic [31:0] page_lo;
      logic [31:0] page_hi;
      near = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!slot_used[i] || slot_space[i] != sp) continue;
        if (slot_lo[i] <= a && a < slot_hi[i]) return ST_HIT;
        // page-rounded window; a rounded end that wraps to 0 leaves it empty
        page_lo = slot_lo[i] & ~PAGE_MASK;
        page_hi = (slot_hi[i] + PAGE_MASK) & ~PAGE_MASK;
        if (page_lo <= a && a < page_hi) near = 1;
      end
      if (near) begin
        resync_needed = 1;
        return ST_NEAR;
      end
      return ST_MISS;
    endfunction

    function void note_request(logic [1:0] mode, logic [15:0] sp, logic [31:0] addr,
                               logic [31:0] size);
      table_reply_t r;
      case (mode)
        MODE_SET:  r.status = apply_set(sp, addr, size);
        MODE_DEL:  r.status = apply_delete(sp, addr);
        MODE_FIND: r.status = apply_find(sp, addr);
        default: begin
          resync_needed = 0;
          r.status      = ST_SYNCED;
        end
      endcase
      r.step = (r.status == ST_NEAR);
      r.pend = resync_needed;
      replies_due.push_back(r);
    endfunction

    function void check_reply(status_t status, logic step, logic pend);
      table_reply_t r;
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding: status=%0d", status);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (step !== r.step) begin
        $error("step_request: expected %0b, got %0b", r.step, step);
        errors++;
      end
      if (pend !== r.pend) begin
        $error("protect_pending: expected %0b, got %0b", r.pend, pend);
        errors++;
      end
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the watchpoint range table
// Directed requests cover duplicates, wrapped and empty ranges, near hits and
// nested deletes; a fill burst hits the full table; random requests follow
// under sender gaps and receiver stalls, checked by the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import wrt_pkg::*;
  import wrt_tb_pkg::*;

  localparam int     RANDOM_ITEMS  = 1500;
  localparam int     FILL_COUNT    = TABLE_DEPTH + 6;
  localparam int     SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam longint CYCLE_LIMIT   = 1_000_000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_SYNC;
  logic [15:0] in_space_id = '0;
  logic [31:0] in_addr = '0;
  logic [31:0] in_size = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [3:0]  out_status;
  logic        out_step_request;
  logic        out_protect_pending;

  int              in_gap_pct = 0;
  int              out_stall_pct = 0;
  longint unsigned cycle_count = 0;
  wrt_scoreboard   table_model = new();

  // ranges issued by random sets, used to aim probes at live entries
  logic [15:0] range_space[$];
  logic [31:0] range_addr[$];
  logic [31:0] range_size[$];

  watchpoint_range_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_space_id        (in_space_id),
    .in_addr            (in_addr),
    .in_size            (in_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_step_request   (out_step_request),
    .out_protect_pending(out_protect_pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      table_model.check_reply(out_status, out_step_request, out_protect_pending);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] mode, logic [15:0] sp, logic [31:0] addr,
                              logic [31:0] size);
    in_valid    = 1;
    in_mode     = mode;
    in_space_id = sp;
    in_addr     = addr;
    in_size     = size;
    do @(posedge clk); while (in_stall !== 1'b0);
    table_model.note_request(mode, sp, addr, size);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
  endtask

  task automatic wait_all_replies();
    in_valid = 0;
    while (table_model.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_space();
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'h0000;
      3, 4:    return 16'h0001;
      5:       return 16'hFFFF;
      6:       return 16'h5A5A;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_region();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0001_0000;
      2:       return 32'h7FFF_F000;
      3:       return 32'hFFFF_C000;
      default: return $urandom & ~PAGE_MASK;
    endcase
  endfunction

  task automatic random_request();
    int          kind;
    int          pick;
    int          k;
    logic [15:0] sp;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] span;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    sp   = pick_space();
    if (kind < 28) begin
      if (range_addr.size() > 0 && pick < 15) begin
        // reissue an earlier range, usually a duplicate
        k    = $urandom_range(0, range_addr.size() - 1);
        sp   = range_space[k];
        addr = range_addr[k];
        size = range_size[k];
      end else begin
        addr = pick_region() + $urandom_range(0, 32'h3FFF);
        if (pick < 23)      size = 0;
        else if (pick < 32) size = $urandom;
        else                size = $urandom_range(1, 32'h1800);
        range_space.push_back(sp);
        range_addr.push_back(addr);
        range_size.push_back(size);
        if (range_addr.size() > 48) begin
          void'(range_space.pop_front());
          void'(range_addr.pop_front());
          void'(range_size.pop_front());
        end
      end
      send_request(MODE_SET, sp, addr, size);
    end else if (kind < 90) begin
      if (range_addr.size() > 0 && pick < 75) begin
        k    = $urandom_range(0, range_addr.size() - 1);
        sp   = range_space[k];
        span = (range_size[k] > 32'h4000) ? 32'h4000 : range_size[k];
        addr = range_addr[k] + $urandom_range(0, span + 32'h2000) - 32'h1000;
      end else begin
        addr = $urandom;
      end
      send_request((kind < 52) ? MODE_DEL : MODE_FIND, sp, addr, $urandom);
    end else begin
      send_request(MODE_SYNC, sp, $urandom, $urandom);
    end
  endtask

  // fill the table past capacity, then take every range back out
  task automatic fill_and_drain();
    logic [31:0] fill_addr[FILL_COUNT];
    for (int i = 0; i < FILL_COUNT; i++) begin
      fill_addr[i] = (32'(i) << 20) | $urandom_range(0, 32'hFFF);
      sender_gap();
      send_request(MODE_SET, 16'h0F0F, fill_addr[i], $urandom_range(1, 32'h2000));
    end
    for (int i = 0; i < FILL_COUNT; i++) begin
      sender_gap();
      send_request(MODE_DEL, 16'h0F0F, fill_addr[i], $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;

    // empty table
    send_request(MODE_SYNC, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_FIND, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(MODE_DEL,  16'h0000, 32'h0000_0000, 32'h0000_0000);
    // plain range, duplicate, hit / near / miss, other space
    send_request(MODE_SET,  16'h0000, 32'h0000_1000, 32'h0000_0100);
    send_request(MODE_SET,  16'h0000, 32'h0000_1000, 32'h0000_0100);
    send_request(MODE_FIND, 16'h0000, 32'h0000_1000, 32'h0);
    send_request(MODE_FIND, 16'h0000, 32'h0000_10FF, 32'h0);
    send_request(MODE_FIND, 16'h0000, 32'h0000_1100, 32'h0);
    send_request(MODE_FIND, 16'h0000, 32'h0000_2000, 32'h0);
    send_request(MODE_FIND, 16'hFFFF, 32'h0000_1000, 32'h0);
    send_request(MODE_SYNC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // end wraps below start: contains nothing, near window empty too
    send_request(MODE_SET,  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_FIND, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_DEL,  16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    // rounded end wraps to zero: exact hit works, near window empty
    send_request(MODE_SET,  16'hFFFF, 32'hFFFF_F000, 32'h0000_0800);
    send_request(MODE_FIND, 16'hFFFF, 32'hFFFF_F7FF, 32'h0);
    send_request(MODE_FIND, 16'hFFFF, 32'hFFFF_F900, 32'h0);
    // zero size and full-width size
    send_request(MODE_SET,  16'h0001, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_SET,  16'h0001, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(MODE_FIND, 16'h0001, 32'hFFFF_FFFE, 32'h0);
    // nested ranges: delete takes the newest containing entry first
    send_request(MODE_SET,  16'h0000, 32'h0000_1000, 32'h0000_1000);
    send_request(MODE_DEL,  16'h0000, 32'h0000_1080, 32'h0);
    send_request(MODE_FIND, 16'h0000, 32'h0000_1800, 32'h0);
    send_request(MODE_DEL,  16'h0000, 32'h0000_1080, 32'h0);
    send_request(MODE_DEL,  16'h0000, 32'h0000_1080, 32'h0);
    wait_all_replies();

    for (int phase = 0; phase < 3; phase++) begin
      in_gap_pct    = (phase == 0) ? 30 : (phase == 1) ? 76 : 0;
      out_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 30 : 0;
      if (phase == 2) fill_and_drain();
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        sender_gap();
        random_request();
      end
      // hold off until the table has answered everything
      wait_all_replies();
    end

    out_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (table_model.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wrt_pkg.sv
sv/wrt_ram.sv
sv/watchpoint_range_table.sv
tb/wrt_tb_pkg.sv
tb/tb.sv
